[hw/rtl/vlmr_pkg.sv]
// Shared types, constants and helpers for the variable-length message ring.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vlmr_pkg;

  // Ring geometry. The ring depth is a power of two so that pointer
  // increments wrap on their own.
  localparam int RING_AW           = 8;
  localparam int RING_WORDS        = 1 << RING_AW;
  localparam int WORD_W            = 32;
  localparam int LEN_W             = 9;
  localparam int MSGW_W            = 8;   // word count of a raw length, up to 128
  localparam int LEFT_W            = 7;   // words left in a push or a pop
  localparam int COUNT_W           = 8;
  localparam int MAX_MESSAGE_WORDS = 64;
  localparam int BYTE_SHIFT        = 2;   // four bytes per word
  localparam int ROOM_W            = RING_AW + 2;

  localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

  // Request operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_PUSH_OK   = 2'd0;
  localparam logic [1:0] KIND_PUSH_FULL = 2'd1;
  localparam logic [1:0] KIND_POP_WORD  = 2'd2;
  localparam logic [1:0] KIND_POP_EMPTY = 2'd3;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH_DROP,
    CMD_PUSH_BODY,
    CMD_PUSH_REJECT,
    CMD_PUSH_HEAD,
    CMD_PUSH_FIRST,
    CMD_POP_EMPTY,
    CMD_POP_HDR_RD,
    CMD_POP_START,
    CMD_POP_WORD
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;    // result register can take a result this cycle
    logic left_nz;     // a push is in progress
    logic rejected;    // the push in progress was refused
    logic fits;        // a new push of the offered length has room
    logic count_zero;  // no message stored
    logic pop_last;    // the word now read is the last of the message
  } stat_t;

  // Number of words that a byte length occupies, rounded up.
  function automatic logic [MSGW_W-1:0] words_of(input logic [LEN_W-1:0] len);
    logic [LEN_W:0] sum;
    begin
      sum = {1'b0, len} + (LEN_W+1)'((1 << BYTE_SHIFT) - 1);
      words_of = sum[LEN_W:BYTE_SHIFT];
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/vlmr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; the read data holds until the next read is issued.
`timescale 1ns / 1ps
`default_nettype none

module vlmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/vlmr_ctrl.sv]
// Controller state machine of the message ring: sequences push and pop requests.
// Depends on vlmr_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module vlmr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_op,
  input  wire vlmr_pkg::stat_t stat,
  output logic                 in_tready,
  output vlmr_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH_FIRST,
    ST_POP_HDR,
    ST_POP_WORD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = vlmr_pkg::CMD_NONE;
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE) && stat.out_free;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && stat.out_free) begin
          if (in_op == vlmr_pkg::OP_PUSH) begin
            if (stat.left_nz) begin
              cmd = stat.rejected ? vlmr_pkg::CMD_PUSH_DROP : vlmr_pkg::CMD_PUSH_BODY;
            end else if (stat.fits) begin
              cmd       = vlmr_pkg::CMD_PUSH_HEAD;
              state_nxt = ST_PUSH_FIRST;
            end else begin
              cmd = vlmr_pkg::CMD_PUSH_REJECT;
            end
          end else if (stat.count_zero) begin
            cmd = vlmr_pkg::CMD_POP_EMPTY;
          end else begin
            cmd       = vlmr_pkg::CMD_POP_HDR_RD;
            state_nxt = ST_POP_HDR;
          end
        end
      end
      ST_PUSH_FIRST: begin
        // The result register drained when the request was taken.
        cmd       = vlmr_pkg::CMD_PUSH_FIRST;
        state_nxt = ST_IDLE;
      end
      ST_POP_HDR: begin
        cmd       = vlmr_pkg::CMD_POP_START;
        state_nxt = ST_POP_WORD;
      end
      ST_POP_WORD: begin
        if (stat.out_free) begin
          cmd = vlmr_pkg::CMD_POP_WORD;
          if (stat.pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/vlmr_dp.sv]
// Datapath of the message ring: pointers, counters, ring memory and result register.
// Depends on vlmr_pkg and vlmr_ram; driven by commands from vlmr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module vlmr_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire vlmr_pkg::cmd_t                     cmd,
  input  wire logic [vlmr_pkg::LEN_W-1:0]         in_len,
  input  wire logic [vlmr_pkg::WORD_W-1:0]        in_data,
  input  wire logic                               out_tready,
  output vlmr_pkg::stat_t                         stat,
  output logic                                    out_valid,
  output logic [1:0]                              out_kind,
  output logic [vlmr_pkg::WORD_W-1:0]             out_data,
  output logic [vlmr_pkg::LEN_W-1:0]              out_len,
  output logic                                    out_last,
  output logic [vlmr_pkg::COUNT_W-1:0]            out_pend
);

  localparam int AW = vlmr_pkg::RING_AW;
  localparam int PW = vlmr_pkg::ROOM_W;

  // Control state.
  logic [AW-1:0]                     head_r, head_nxt;
  logic [AW-1:0]                     tail_r, tail_nxt;
  logic [AW-1:0]                     cursor_r, cursor_nxt;
  logic [AW-1:0]                     rd_ptr_r, rd_ptr_nxt;
  logic [vlmr_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [vlmr_pkg::LEFT_W-1:0]       left_r, left_nxt;
  logic [vlmr_pkg::LEFT_W-1:0]       pop_left_r, pop_left_nxt;
  logic                              rej_r, rej_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // Payload state.
  logic [vlmr_pkg::WORD_W-1:0]       word_r, word_nxt;
  logic [vlmr_pkg::LEN_W-1:0]        pop_len_r, pop_len_nxt;
  logic [1:0]                        out_kind_r, out_kind_nxt;
  logic [vlmr_pkg::WORD_W-1:0]       out_data_r, out_data_nxt;
  logic [vlmr_pkg::LEN_W-1:0]        out_len_r, out_len_nxt;
  logic                              out_last_r, out_last_nxt;
  logic [vlmr_pkg::COUNT_W-1:0]      out_pend_r, out_pend_nxt;

  // Memory port.
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [vlmr_pkg::WORD_W-1:0]       wr_data;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic [vlmr_pkg::WORD_W-1:0]       rd_data;

  // Room check for a new push.
  logic [vlmr_pkg::MSGW_W-1:0]       new_w;
  logic [PW-1:0]                     new_w1;
  logic [PW-1:0]                     room;
  logic                              place_after;
  logic                              place_wrap;
  logic                              fits;

  // Header decode for a pop.
  logic [vlmr_pkg::LEN_W-1:0]        hdr_len;
  logic [vlmr_pkg::MSGW_W-1:0]       hdr_w_raw;
  logic [vlmr_pkg::LEFT_W-1:0]       hdr_w;
  logic [PW-1:0]                     hdr_end;
  logic [AW-1:0]                     pop_start;

  // Payload store shared by the first and later words of a push.
  logic                              store;
  logic [vlmr_pkg::WORD_W-1:0]       store_word;
  logic [vlmr_pkg::LEFT_W-1:0]       store_left;

  vlmr_ram #(
    .WIDTH (vlmr_pkg::WORD_W),
    .DEPTH (vlmr_pkg::RING_WORDS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    new_w  = vlmr_pkg::words_of(in_len);
    new_w1 = PW'(new_w) + PW'(1);
    room   = PW'(vlmr_pkg::RING_WORDS) - PW'(tail_r);
    place_after = 1'b0;
    place_wrap  = 1'b0;
    if (head_r <= tail_r) begin
      if ((room > new_w1) || ((room == new_w1) && (head_r != '0))) begin
        place_after = 1'b1;
      end else if (PW'(head_r) > PW'(new_w)) begin
        place_wrap = 1'b1;
      end
    end else if (PW'(head_r - tail_r) > new_w1) begin
      place_after = 1'b1;
    end
    fits = (in_len != '0)
        && (new_w <= vlmr_pkg::MSGW_W'(vlmr_pkg::MAX_MESSAGE_WORDS))
        && (count_r != vlmr_pkg::COUNT_FULL)
        && (place_after || place_wrap);
  end

  always_comb begin
    hdr_len   = rd_data[vlmr_pkg::LEN_W-1:0];
    hdr_w_raw = vlmr_pkg::words_of(hdr_len);
    if (hdr_w_raw == '0) begin
      hdr_w = vlmr_pkg::LEFT_W'(1);
    end else if (hdr_w_raw > vlmr_pkg::MSGW_W'(vlmr_pkg::MAX_MESSAGE_WORDS)) begin
      hdr_w = vlmr_pkg::LEFT_W'(vlmr_pkg::MAX_MESSAGE_WORDS);
    end else begin
      hdr_w = hdr_w_raw[vlmr_pkg::LEFT_W-1:0];
    end
    hdr_end = PW'(head_r) + PW'(hdr_w) + PW'(1);
    if (hdr_end > PW'(vlmr_pkg::RING_WORDS)) begin
      pop_start = '0;
    end else begin
      pop_start = head_r + AW'(1);
    end
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cursor_nxt    = cursor_r;
    rd_ptr_nxt    = rd_ptr_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    pop_left_nxt  = pop_left_r;
    rej_nxt       = rej_r;
    word_nxt      = word_r;
    pop_len_nxt   = pop_len_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    out_pend_nxt  = out_pend_r;
    wr_en         = 1'b0;
    wr_addr       = cursor_r;
    wr_data       = in_data;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    store         = 1'b0;
    store_word    = in_data;

    case (cmd)
      vlmr_pkg::CMD_PUSH_DROP: begin
        left_nxt      = left_r - vlmr_pkg::LEFT_W'(1);
        out_valid_nxt = 1'b1;
        out_kind_nxt  = vlmr_pkg::KIND_PUSH_FULL;
      end
      vlmr_pkg::CMD_PUSH_REJECT: begin
        rej_nxt       = 1'b1;
        left_nxt      = (new_w != '0) ? vlmr_pkg::LEFT_W'(new_w - vlmr_pkg::MSGW_W'(1)) : '0;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = vlmr_pkg::KIND_PUSH_FULL;
      end
      vlmr_pkg::CMD_PUSH_HEAD: begin
        rej_nxt    = 1'b0;
        wr_en      = 1'b1;
        wr_addr    = tail_r;
        wr_data    = vlmr_pkg::WORD_W'(in_len);
        cursor_nxt = place_after ? tail_r + AW'(1) : '0;
        left_nxt   = new_w[vlmr_pkg::LEFT_W-1:0];
        word_nxt   = in_data;
      end
      vlmr_pkg::CMD_PUSH_FIRST: begin
        store      = 1'b1;
        store_word = word_r;
      end
      vlmr_pkg::CMD_PUSH_BODY: begin
        store = 1'b1;
      end
      vlmr_pkg::CMD_POP_EMPTY: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = vlmr_pkg::KIND_POP_EMPTY;
      end
      vlmr_pkg::CMD_POP_HDR_RD: begin
        rd_en   = 1'b1;
        rd_addr = head_r;
      end
      vlmr_pkg::CMD_POP_START: begin
        if (hdr_end > PW'(vlmr_pkg::RING_WORDS)) begin
          head_nxt = AW'(hdr_w);
        end else begin
          head_nxt = hdr_end[AW-1:0];
        end
        count_nxt    = count_r - vlmr_pkg::COUNT_W'(1);
        pop_len_nxt  = hdr_len;
        pop_left_nxt = hdr_w;
        rd_en        = 1'b1;
        rd_addr      = pop_start;
        rd_ptr_nxt   = pop_start + AW'(1);
      end
      vlmr_pkg::CMD_POP_WORD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = vlmr_pkg::KIND_POP_WORD;
        out_data_nxt  = rd_data;
        out_len_nxt   = pop_len_r;
        out_last_nxt  = (pop_left_r == vlmr_pkg::LEFT_W'(1));
        out_pend_nxt  = count_r;
        pop_left_nxt  = pop_left_r - vlmr_pkg::LEFT_W'(1);
        if (pop_left_r != vlmr_pkg::LEFT_W'(1)) begin
          rd_en      = 1'b1;
          rd_addr    = rd_ptr_r;
          rd_ptr_nxt = rd_ptr_r + AW'(1);
        end
      end
      default: begin
      end
    endcase

    // Payload word write; the message commits on its last word.
    store_left = left_r - vlmr_pkg::LEFT_W'(1);
    if (store) begin
      wr_en         = 1'b1;
      wr_addr       = cursor_r;
      wr_data       = store_word;
      cursor_nxt    = cursor_r + AW'(1);
      left_nxt      = store_left;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = vlmr_pkg::KIND_PUSH_OK;
      if (store_left == '0) begin
        tail_nxt  = cursor_r + AW'(1);
        count_nxt = count_r + vlmr_pkg::COUNT_W'(1);
      end
    end

    // Every result but a popped word carries zeros and the count after the step.
    if (out_valid_nxt && (cmd != vlmr_pkg::CMD_POP_WORD) && (cmd != vlmr_pkg::CMD_NONE)
        && (cmd != vlmr_pkg::CMD_POP_HDR_RD) && (cmd != vlmr_pkg::CMD_POP_START)
        && (cmd != vlmr_pkg::CMD_PUSH_HEAD)) begin
      out_data_nxt = '0;
      out_len_nxt  = '0;
      out_last_nxt = 1'b0;
      out_pend_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cursor_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      left_r      <= '0;
      pop_left_r  <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cursor_r    <= cursor_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      pop_left_r  <= pop_left_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    pop_len_r  <= pop_len_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
    out_pend_r <= out_pend_nxt;
  end

  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.left_nz    = (left_r != '0);
  assign stat.rejected   = rej_r;
  assign stat.fits       = fits;
  assign stat.count_zero = (count_r == '0);
  assign stat.pop_last   = (pop_left_r == vlmr_pkg::LEFT_W'(1));

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_len   = out_len_r;
  assign out_last  = out_last_r;
  assign out_pend  = out_pend_r;

endmodule

`default_nettype wire

[hw/rtl/variable_length_message_ring_core.sv]
// Top level of the variable-length message ring: stream ports, controller and datapath.
// Depends on vlmr_pkg, vlmr_ctrl, vlmr_dp (and vlmr_ram inside the datapath).
//
//   Channel | Ports                           | Carries
//   --------+---------------------------------+--------------------------------------
//   in_     | tvalid tready tdata tuser       | push word (with length) or pop request
//   out_    | tvalid tready tdata tuser tlast | push status, popped words, pop-empty
//
// A continuing push word, a refused push and a pop of an empty ring are handled in the idle state alone.
// An accepted push writes its header, then its first word, as header and payload share one write port.
// A pop reads the header, then decodes it and starts the payload read, then sends one word
// per cycle while the result side does not stall.
// Reset (synchronous, rst_n low) empties the ring; the memory itself is not cleared.
// A stall on the result side holds the result register and the pop sequence in place.
`timescale 1ns / 1ps
`default_nettype none

module variable_length_message_ring_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [8:0] length_bytes, [40:9] data_word, rest zero
  input  wire logic        in_tuser,   // [0] operation
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [31:0] data_word_out, [40:32] length_out,
                                       // [48:41] pending_messages, rest zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last_word
);

  vlmr_pkg::cmd_t                       cmd;
  vlmr_pkg::stat_t                      stat;
  logic [1:0]                           res_kind;
  logic [vlmr_pkg::WORD_W-1:0]          res_data;
  logic [vlmr_pkg::LEN_W-1:0]           res_len;
  logic [vlmr_pkg::COUNT_W-1:0]         res_pend;

  // The controller accepts a request only when the result register can take
  // the result it causes, and only between requests; a pop then walks its
  // message out word by word before the next request is taken.
  vlmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // The datapath owns the ring pointers, the message count, the ring memory
  // and the result register that parts the two channels.
  vlmr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_len     (in_tdata[8:0]),
    .in_data    (in_tdata[40:9]),
    .out_tready (out_tready),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_kind   (res_kind),
    .out_data   (res_data),
    .out_len    (res_len),
    .out_last   (out_tlast),
    .out_pend   (res_pend)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {7'b0, res_pend, res_len, res_data};

`ifndef NO_ASSERTIONS
  // A request is only taken when its result has somewhere to go.
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("request taken while the result register is blocked");

  // Only popped words carry a length or a last-word mark.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != vlmr_pkg::KIND_POP_WORD))
      |-> (!out_tlast && (res_len == '0) && (res_data == '0)))
    else $error("status result carries payload fields");

  // An empty pop can only be reported with no message left in the ring.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == vlmr_pkg::KIND_POP_EMPTY)) |-> (res_pend == '0))
    else $error("pop reported empty with messages pending");

  // No new request is taken while a popped message is still being sent.
  a_no_accept_mid_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == vlmr_pkg::KIND_POP_WORD) && !out_tlast) |-> !in_tready)
    else $error("request taken in the middle of a popped message");
`endif

endmodule

`default_nettype wire
